// ===== sv/cspline_pkg.sv =====
// Shared types, widths and helpers for the centripetal spline segment builder.
// Used by the controller, the datapath, the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package cspline_pkg;

    localparam int COORD_W    = 32;
    localparam int SEG_W      = 16;               // segment counter width
    localparam int SEGNUM_W   = 16;               // segment_number field width
    localparam int COEF_W     = 40;
    localparam int PT_W       = COORD_W + 2;      // mirrored points
    localparam int DIFF_W     = PT_W + 1;
    localparam int MAG_W      = DIFF_W;
    localparam int KNOT_W     = 22;
    localparam int KSUM_W     = KNOT_W + 1;
    localparam int SUM_W      = 2 * MAG_W + 2;
    localparam int FRAC_W     = 16;
    localparam int RAD_W      = 88;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SREM_W     = ROOT_W + 4;
    localparam int MB_W       = 36;
    localparam int PROD_W     = 100;
    localparam int DEN_W      = 64;
    localparam int DREM_W     = DEN_W + 1;
    localparam int T_W        = 60;
    localparam int N_W        = T_W + 1;
    localparam int Q_W        = 61;
    localparam int M_W        = 64;
    localparam int CO_W       = 66;
    localparam int CNT_W      = 7;

    localparam int MUL_STEPS  = MB_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = PROD_W;

    localparam logic [PROD_W-1:0] QUOT_CAP = PROD_W'(1) << (Q_W - 1);
    localparam logic signed [CO_W-1:0] COEF_HI =
        {{(CO_W - COEF_W + 1){1'b0}}, {(COEF_W - 1){1'b1}}};
    localparam logic signed [CO_W-1:0] COEF_LO =
        {{(CO_W - COEF_W + 1){1'b1}}, {(COEF_W - 1){1'b0}}};

    localparam logic [1:0] AXIS_FIRST  = 2'd0;
    localparam logic [1:0] AXIS_LAST   = 2'd2;
    localparam logic [1:0] POWER_FIRST = 2'd0;
    localparam logic [1:0] POWER_LAST  = 2'd3;
    localparam logic [1:0] DIFF_PREV   = 2'd0;
    localparam logic [1:0] DIFF_MID    = 2'd1;
    localparam logic [1:0] DIFF_NEXT   = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE, OP_SQ, OP_ROOT1, OP_ROOT2, OP_MUL_A, OP_MUL_B, OP_MUL_D, OP_MUL_P, OP_DIV
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_SQ, ST_ROOT1, ST_ROOT2, ST_CHECK, ST_MUL_A, ST_MUL_B,
        ST_MUL_D, ST_MUL_P, ST_DIV, ST_EMIT, ST_NEXT_SEG, ST_FINISH
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic                      final_point;
    } in_item_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic [1:0]               axis;
        logic [1:0]               power;
        logic [SEGNUM_W-1:0]      segment_number;
        logic                     degenerate;
        logic                     run_end;
    } out_item_t;

    typedef struct packed {
        op_t        op;
        logic       start;
        logic [1:0] kidx;
        logic [1:0] axis;
        logic [1:0] power;
        logic       side;
        logic       accept;
        logic       load_seg;
        logic       final_seg;
        logic       mirror;
        logic       emit;
        logic       run_end;
        logic       seg_inc;
        logic       seg_clear;
        logic       shift_win;
    } cmd_t;

    typedef struct packed {
        logic unit_done;
        logic degen;
        logic out_free;
    } stat_t;

    function automatic logic [MAG_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] x);
        logic signed [DIFF_W-1:0] neg;
        begin
            neg = -x;
            return (x < 0) ? MAG_W'(unsigned'(neg)) : MAG_W'(unsigned'(x));
        end
    endfunction

    function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [CO_W-1:0] x);
        begin
            if (x > COEF_HI) begin
                return COEF_W'(COEF_HI);
            end else if (x < COEF_LO) begin
                return COEF_W'(COEF_LO);
            end
            return COEF_W'(x);
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/cspline_ctrl.sv =====
// Sequencing controller for the spline segment builder.
// Depends on cspline_pkg; drives the datapath through cmd_t and reads stat_t.
`timescale 1ns / 1ps
`default_nettype none

module cspline_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_final,
    output logic                    s_ready,
    input  wire cspline_pkg::stat_t stat,
    output cspline_pkg::cmd_t       cmd
);
    import cspline_pkg::*;

    state_t     state_reg, state_next;
    logic       launched_reg, launched_next;
    logic [1:0] kidx_reg, kidx_next;
    logic [1:0] axis_reg, axis_next;
    logic [1:0] power_reg, power_next;
    logic       side_reg, side_next;
    logic       final_seg_reg, final_seg_next;
    logic       mirror_reg, mirror_next;
    logic       do_final_reg, do_final_next;
    logic       fin_reg, fin_next;
    logic [1:0] seen_reg, seen_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            launched_reg  <= 1'b0;
            kidx_reg      <= 2'd0;
            axis_reg      <= AXIS_FIRST;
            power_reg     <= POWER_FIRST;
            side_reg      <= 1'b0;
            final_seg_reg <= 1'b0;
            mirror_reg    <= 1'b0;
            do_final_reg  <= 1'b0;
            fin_reg       <= 1'b0;
            seen_reg      <= 2'd0;
        end else begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            kidx_reg      <= kidx_next;
            axis_reg      <= axis_next;
            power_reg     <= power_next;
            side_reg      <= side_next;
            final_seg_reg <= final_seg_next;
            mirror_reg    <= mirror_next;
            do_final_reg  <= do_final_next;
            fin_reg       <= fin_next;
            seen_reg      <= seen_next;
        end
    end

    always_comb begin
        logic unit_state;
        logic go_on;
        state_next     = state_reg;
        launched_next  = launched_reg;
        kidx_next      = kidx_reg;
        axis_next      = axis_reg;
        power_next     = power_reg;
        side_next      = side_reg;
        final_seg_next = final_seg_reg;
        mirror_next    = mirror_reg;
        do_final_next  = do_final_reg;
        fin_next       = fin_reg;
        seen_next      = seen_reg;

        cmd           = '0;
        cmd.op        = OP_NONE;
        cmd.kidx      = kidx_reg;
        cmd.axis      = axis_reg;
        cmd.power     = power_reg;
        cmd.side      = side_reg;
        cmd.final_seg = final_seg_reg;
        cmd.mirror    = mirror_reg;
        s_ready       = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_SQ:    cmd.op = OP_SQ;
            ST_ROOT1: cmd.op = OP_ROOT1;
            ST_ROOT2: cmd.op = OP_ROOT2;
            ST_MUL_A: cmd.op = OP_MUL_A;
            ST_MUL_B: cmd.op = OP_MUL_B;
            ST_MUL_D: cmd.op = OP_MUL_D;
            ST_MUL_P: cmd.op = OP_MUL_P;
            ST_DIV:   cmd.op = OP_DIV;
            default:  cmd.op = OP_NONE;
        endcase

        // Every unit state launches its operation once, then waits for completion.
        unit_state = (cmd.op != OP_NONE);
        go_on      = 1'b0;
        if (unit_state) begin
            if (!launched_reg) begin
                cmd.start     = 1'b1;
                launched_next = 1'b1;
            end else if (stat.unit_done) begin
                launched_next = 1'b0;
                go_on         = 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept    = 1'b1;
                    fin_next      = s_final;
                    do_final_next = s_final && (seen_reg != 2'd0);
                    if (seen_reg >= 2'd2) begin
                        final_seg_next = 1'b0;
                        mirror_next    = (seen_reg == 2'd2);
                        state_next     = ST_LOAD;
                    end else if (s_final && (seen_reg == 2'd1)) begin
                        final_seg_next = 1'b1;
                        mirror_next    = 1'b1;
                        state_next     = ST_LOAD;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load_seg = 1'b1;
                kidx_next    = DIFF_PREV;
                axis_next    = AXIS_FIRST;
                state_next   = ST_SQ;
            end
            ST_SQ: begin
                if (go_on) begin
                    if (axis_reg == AXIS_LAST) begin
                        axis_next  = AXIS_FIRST;
                        state_next = ST_ROOT1;
                    end else begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
            end
            ST_ROOT1: begin
                if (go_on) begin
                    state_next = ST_ROOT2;
                end
            end
            ST_ROOT2: begin
                if (go_on) begin
                    if (kidx_reg == DIFF_NEXT) begin
                        axis_next  = AXIS_FIRST;
                        state_next = ST_CHECK;
                    end else begin
                        kidx_next  = kidx_reg + 2'd1;
                        state_next = ST_SQ;
                    end
                end
            end
            ST_CHECK: begin
                side_next  = 1'b0;
                power_next = POWER_FIRST;
                state_next = stat.degen ? ST_EMIT : ST_MUL_A;
            end
            ST_MUL_A: if (go_on) state_next = ST_MUL_B;
            ST_MUL_B: if (go_on) state_next = ST_MUL_D;
            ST_MUL_D: if (go_on) state_next = ST_MUL_P;
            ST_MUL_P: if (go_on) state_next = ST_DIV;
            ST_DIV: begin
                if (go_on) begin
                    if (!side_reg) begin
                        side_next  = 1'b1;
                        state_next = ST_MUL_A;
                    end else begin
                        power_next = POWER_FIRST;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.run_end = (axis_reg == AXIS_LAST) && (power_reg == POWER_LAST)
                                  && (final_seg_reg || !do_final_reg);
                    if (power_reg == POWER_LAST) begin
                        power_next = POWER_FIRST;
                        side_next  = 1'b0;
                        if (axis_reg == AXIS_LAST) begin
                            state_next = ST_NEXT_SEG;
                        end else begin
                            axis_next  = axis_reg + 2'd1;
                            state_next = stat.degen ? ST_EMIT : ST_MUL_A;
                        end
                    end else begin
                        power_next = power_reg + 2'd1;
                    end
                end
            end
            ST_NEXT_SEG: begin
                cmd.seg_inc = 1'b1;
                if (!final_seg_reg && do_final_reg) begin
                    final_seg_next = 1'b1;
                    mirror_next    = (seen_reg == 2'd1);
                    state_next     = ST_LOAD;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.shift_win = 1'b1;
                cmd.seg_clear = fin_reg;
                if (fin_reg) begin
                    seen_next = 2'd0;
                end else if (seen_reg != 2'd3) begin
                    seen_next = seen_reg + 2'd1;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/cspline_dp.sv =====
// Datapath of the spline segment builder: point window, serial multiplier,
// digit-by-digit square root, restoring divider and the result register.
// Depends on cspline_pkg; controlled by cspline_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module cspline_dp (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cspline_pkg::in_item_t  s_data,
    input  wire cspline_pkg::cmd_t      cmd,
    output cspline_pkg::stat_t          stat,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output cspline_pkg::out_item_t      m_data
);
    import cspline_pkg::*;

    // Point storage and segment geometry.
    logic signed [COORD_W-1:0] win_reg [3][3];
    logic signed [COORD_W-1:0] in_reg  [3];
    logic signed [DIFF_W-1:0]  d_reg   [3][3];
    logic signed [PT_W-1:0]    c0_reg  [3];

    // Intermediate results.
    logic [SUM_W-1:0]          sum_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [KNOT_W-1:0]         knot_u_reg, knot_v_reg, knot_w_reg;
    logic signed [T_W-1:0]     t1_reg, t2_reg;
    logic                      sa_reg, sb_reg, neg_reg;
    logic signed [DIFF_W-1:0]  d21_reg;
    logic [DEN_W-1:0]          den_reg;
    logic signed [M_W-1:0]     m_reg [2];

    // Shared iterative units.
    logic                      busy_reg;
    logic [CNT_W-1:0]          cnt_reg;
    op_t                       op_reg;
    logic [PROD_W-1:0]         ma_reg, macc_reg;
    logic [MB_W-1:0]           mb_reg;
    logic [RAD_W-1:0]          rad_reg;
    logic [SREM_W-1:0]         srem_reg;
    logic [ROOT_W-1:0]         sroot_reg;
    logic [PROD_W-1:0]         dvd_reg;
    logic [DREM_W-1:0]         drem_reg;
    logic [DEN_W-1:0]          dden_reg;

    logic [SEG_W-1:0]          seg_cnt_reg;
    logic                      out_valid_reg;
    out_item_t                 out_reg;

    // Segment points, including the mirrored end points.
    logic signed [PT_W-1:0]    qp [4][3];
    logic signed [PT_W-1:0]    sp [4][3];
    logic signed [DIFF_W-1:0]  nd [3][3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
                qp[k][c] = PT_W'(win_reg[k][c]);
            end
            qp[3][c] = PT_W'(in_reg[c]);
            if (!cmd.final_seg) begin
                sp[0][c] = cmd.mirror ? (qp[1][c] <<< 1) - qp[2][c] : qp[0][c];
                sp[1][c] = qp[1][c];
                sp[2][c] = qp[2][c];
                sp[3][c] = qp[3][c];
            end else begin
                sp[0][c] = cmd.mirror ? (qp[2][c] <<< 1) - qp[3][c] : qp[1][c];
                sp[1][c] = qp[2][c];
                sp[2][c] = qp[3][c];
                sp[3][c] = (qp[3][c] <<< 1) - qp[2][c];
            end
            for (int k = 0; k < 3; k++) begin
                nd[k][c] = DIFF_W'(sp[k + 1][c]) - DIFF_W'(sp[k][c]);
            end
        end
    end

    // Operand selection at the launch of a unit operation.
    logic [1:0]               dk;
    logic signed [DIFF_W-1:0] d_sel;
    logic [MAG_W-1:0]         d_mag;
    logic [KNOT_W-1:0]        knot_side;
    logic signed [N_W-1:0]    n_val, n_neg;
    logic [N_W-1:0]           n_mag;
    logic [PROD_W-1:0]        ma_init;
    logic [MB_W-1:0]          mb_init;
    logic [KSUM_W-1:0]        ksum;

    always_comb begin
        unique case (cmd.op)
            OP_SQ:    dk = cmd.kidx;
            OP_MUL_A: dk = cmd.side ? DIFF_NEXT : DIFF_PREV;
            default:  dk = DIFF_MID;
        endcase
        d_sel     = d_reg[dk][cmd.axis];
        d_mag     = abs_diff(d_sel);
        knot_side = cmd.side ? knot_w_reg : knot_u_reg;
        ksum      = KSUM_W'(knot_side) + KSUM_W'(knot_v_reg);
        n_val     = N_W'(t1_reg) - N_W'(t2_reg);
        n_neg     = -n_val;
        n_mag     = (n_val < 0) ? unsigned'(n_neg) : unsigned'(n_val);
        unique case (cmd.op)
            OP_SQ: begin
                ma_init = PROD_W'(d_mag);
                mb_init = MB_W'(d_mag);
            end
            OP_MUL_A: begin
                ma_init = PROD_W'(d_mag);
                mb_init = MB_W'(knot_v_reg);
            end
            OP_MUL_B: begin
                ma_init = PROD_W'(d_mag);
                mb_init = MB_W'(knot_side);
            end
            OP_MUL_D: begin
                ma_init = PROD_W'(ksum);
                mb_init = MB_W'(knot_side);
            end
            OP_MUL_P: begin
                ma_init = PROD_W'(n_mag);
                mb_init = MB_W'(knot_v_reg);
            end
            default: begin
                ma_init = '0;
                mb_init = '0;
            end
        endcase
    end

    // One iteration of each unit.
    logic [PROD_W-1:0] macc_n;
    logic [SREM_W-1:0] scur, strial, srem_n;
    logic [ROOT_W-1:0] sroot_n;
    logic [DREM_W-1:0] dcur, drem_n;
    logic              dge;
    logic [PROD_W-1:0] dvd_n;
    logic [CNT_W-1:0]  last_cnt;
    logic              is_mul, is_root, done;

    always_comb begin
        macc_n = macc_reg + (mb_reg[0] ? ma_reg : '0);

        scur   = {srem_reg[SREM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
        strial = SREM_W'({sroot_reg, 2'b01});
        if (scur >= strial) begin
            srem_n  = scur - strial;
            sroot_n = {sroot_reg[ROOT_W-2:0], 1'b1};
        end else begin
            srem_n  = scur;
            sroot_n = {sroot_reg[ROOT_W-2:0], 1'b0};
        end

        dcur   = {drem_reg[DREM_W-2:0], dvd_reg[PROD_W-1]};
        dge    = (dcur >= {1'b0, dden_reg});
        drem_n = dge ? dcur - {1'b0, dden_reg} : dcur;
        dvd_n  = {dvd_reg[PROD_W-2:0], dge};

        is_mul  = (op_reg == OP_SQ) || (op_reg == OP_MUL_A) || (op_reg == OP_MUL_B)
                  || (op_reg == OP_MUL_D) || (op_reg == OP_MUL_P);
        is_root = (op_reg == OP_ROOT1) || (op_reg == OP_ROOT2);
        if (is_mul) begin
            last_cnt = CNT_W'(MUL_STEPS - 1);
        end else if (is_root) begin
            last_cnt = CNT_W'(SQRT_STEPS - 1);
        end else begin
            last_cnt = CNT_W'(DIV_STEPS - 1);
        end
        done = busy_reg && (cnt_reg == last_cnt);
    end

    // Clamped quotient and the resulting tangent term.
    logic [PROD_W-1:0]     quot_c;
    logic signed [M_W-1:0] q_signed, m_new;
    logic signed [T_W-1:0] prod_t, prod_t_neg;

    always_comb begin
        quot_c     = (dvd_n > QUOT_CAP) ? QUOT_CAP : dvd_n;
        q_signed   = M_W'(quot_c[Q_W-1:0]);
        m_new      = M_W'(d21_reg) + (neg_reg ? -q_signed : q_signed);
        prod_t     = T_W'(macc_n);
        prod_t_neg = -prod_t;
    end

    // Coefficient of the current axis and power.
    logic signed [CO_W-1:0] d21e, m1e, m2e, co;
    logic                   degen;

    always_comb begin
        degen = (knot_u_reg == '0) || (knot_v_reg == '0) || (knot_w_reg == '0);
        d21e  = CO_W'(d21_reg);
        m1e   = CO_W'(m_reg[0]);
        m2e   = CO_W'(m_reg[1]);
        case (cmd.power)
            2'd0:    co = CO_W'(c0_reg[cmd.axis]);
            2'd1:    co = m1e;
            2'd2:    co = (d21e <<< 1) + d21e - (m1e <<< 1) - m2e;
            default: co = m1e + m2e - (d21e <<< 1);
        endcase
        if (degen) begin
            co = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            op_reg        <= OP_NONE;
            seg_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                op_reg   <= cmd.op;
            end else if (done) begin
                busy_reg <= 1'b0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.seg_clear) begin
                seg_cnt_reg <= '0;
            end else if (cmd.seg_inc) begin
                seg_cnt_reg <= seg_cnt_reg + SEG_W'(1);
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_reg[0] <= s_data.coord_x;
            in_reg[1] <= s_data.coord_y;
            in_reg[2] <= s_data.coord_z;
        end
        if (cmd.shift_win) begin
            for (int c = 0; c < 3; c++) begin
                win_reg[0][c] <= win_reg[1][c];
                win_reg[1][c] <= win_reg[2][c];
                win_reg[2][c] <= in_reg[c];
            end
        end
        if (cmd.load_seg) begin
            for (int c = 0; c < 3; c++) begin
                c0_reg[c] <= sp[1][c];
                for (int k = 0; k < 3; k++) begin
                    d_reg[k][c] <= nd[k][c];
                end
            end
        end

        if (cmd.start) begin
            ma_reg   <= ma_init;
            mb_reg   <= mb_init;
            macc_reg <= '0;
            rad_reg  <= (cmd.op == OP_ROOT1) ? RAD_W'({sum_reg, {FRAC_W{1'b0}}})
                                             : RAD_W'(root_reg);
            srem_reg  <= '0;
            sroot_reg <= '0;
            dvd_reg   <= macc_reg;
            drem_reg  <= '0;
            dden_reg  <= den_reg;
            if (cmd.op == OP_MUL_A) begin
                sa_reg <= d_sel[DIFF_W-1];
            end
            if (cmd.op == OP_MUL_B) begin
                sb_reg  <= d_sel[DIFF_W-1];
                d21_reg <= d_sel;
            end
            if (cmd.op == OP_MUL_P) begin
                neg_reg <= n_val[N_W-1];
            end
        end else if (busy_reg) begin
            if (is_mul) begin
                macc_reg <= macc_n;
                ma_reg   <= ma_reg << 1;
                mb_reg   <= mb_reg >> 1;
            end
            if (is_root) begin
                rad_reg   <= rad_reg << 2;
                srem_reg  <= srem_n;
                sroot_reg <= sroot_n;
            end
            if (op_reg == OP_DIV) begin
                dvd_reg  <= dvd_n;
                drem_reg <= drem_n;
            end
        end

        // Results land on the edge of the last iteration.
        if (done) begin
            case (op_reg)
                OP_SQ: begin
                    sum_reg <= ((cmd.axis == AXIS_FIRST) ? '0 : sum_reg) + SUM_W'(macc_n);
                end
                OP_ROOT1: root_reg <= sroot_n;
                OP_ROOT2: begin
                    case (cmd.kidx)
                        DIFF_PREV: knot_u_reg <= KNOT_W'(sroot_n);
                        DIFF_MID:  knot_v_reg <= KNOT_W'(sroot_n);
                        default:   knot_w_reg <= KNOT_W'(sroot_n);
                    endcase
                end
                OP_MUL_A: t1_reg  <= sa_reg ? prod_t_neg : prod_t;
                OP_MUL_B: t2_reg  <= sb_reg ? prod_t_neg : prod_t;
                OP_MUL_D: den_reg <= DEN_W'(macc_n);
                OP_DIV:   m_reg[cmd.side] <= m_new;
                default: ;
            endcase
        end

        if (cmd.emit) begin
            out_reg.coefficient    <= sat_coef(co);
            out_reg.axis           <= cmd.axis;
            out_reg.power          <= cmd.power;
            out_reg.segment_number <= SEGNUM_W'(seg_cnt_reg);
            out_reg.degenerate     <= degen;
            out_reg.run_end        <= cmd.run_end;
        end
    end

    always_comb begin
        stat.unit_done = done;
        stat.degen     = degen;
        stat.out_free  = !out_valid_reg || m_ready;
        m_valid        = out_valid_reg;
        m_data         = out_reg;
    end

endmodule

`default_nettype wire

// ===== sv/centripetal_spline_segment_builder_top.sv =====
// Top level of the centripetal Catmull-Rom segment builder.
// Depends on cspline_pkg, cspline_ctrl and cspline_dp.
`timescale 1ns / 1ps
`default_nettype none

// Takes one Q16.16 control point per transfer and returns, for each finished
// segment, twelve Q24.16 coefficients (x, y, z; powers 0 to 3), so a point gives
// 0, 12 or 24 results. Points are handled one at a time: s_ready is high only
// between points. A segment is built by squaring, square roots and, unless
// degenerate, multiply and divide, then one coefficient is taken per output
// transfer; the work runs on the one shared shift-add multiplier (one bit a
// cycle), the radix-4 root unit and the restoring divider. The last coefficient
// may wait in the output register while the next point is taken.
module centripetal_spline_segment_builder_top (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire cspline_pkg::in_item_t  s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output cspline_pkg::out_item_t      m_data
);
    import cspline_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    cspline_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_final (s_data.final_point),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cspline_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== sv/cspline_chk.sv =====
// Port-level checker for the spline segment builder, bound to the top level.
// Depends on cspline_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cspline_chk (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_valid,
    input wire logic                   s_ready,
    input wire cspline_pkg::in_item_t  s_data,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire cspline_pkg::out_item_t m_data
);
    import cspline_pkg::*;

    // A stalled result transfer keeps its valid.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped before transfer");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The closing result of a point is always the z cubic term.
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.run_end |-> (m_data.axis == AXIS_LAST)
                                      && (m_data.power == POWER_LAST))
        else $error("run end on a result other than the last");

    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> (m_data.coefficient == '0))
        else $error("degenerate segment with nonzero coefficient");

    a_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.axis != 2'd3))
        else $error("axis code out of range");

endmodule

bind centripetal_spline_segment_builder_top cspline_chk u_chk (.*);

`default_nettype wire

// ===== tb/centripetal_spline_segment_builder_top_test.sv =====
// Self-checking bench for the centripetal spline segment builder: directed and random point
// lists are checked coefficient by coefficient against a built-in segment calculator.
// Depends on cspline_pkg and centripetal_spline_segment_builder_top.
`timescale 1ns / 1ps

module centripetal_spline_segment_builder_top_test;
    import cspline_pkg::*;

    typedef logic signed [71:0] wide_t;

    localparam longint CYCLE_LIMIT = 64'd8_000_000;
    localparam int     RANDOM_POINTS = 430;
    localparam int     LONG_HOLD_AT = 300;
    localparam int     LONG_HOLD_CYCLES = 5000;
    localparam int     DRAIN_CYCLES = 3000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    in_item_t s_data;
    logic     m_valid;
    logic     m_ready;
    out_item_t m_data;

    centripetal_spline_segment_builder_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    in_item_t  point_q[$];
    out_item_t coef_q[$];

    // Predictor state: the three previous points of the list, oldest first.
    wide_t       win [3][3];
    int unsigned pts_seen;
    logic [SEG_W-1:0] seg_count;

    int  points_taken;
    int  coefs_taken;
    int  points_issued;
    int  fail_count;
    int  lists_done;
    int  segments_built;
    int  degen_segments;
    longint cycle_count;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] root128(input logic [127:0] x);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (128'd1 << i);
            if (c * c <= x) begin
                r = c;
            end
        end
        return r[63:0];
    endfunction

    function automatic logic [63:0] knot_len(input wide_t dx, input wide_t dy, input wide_t dz);
        logic [127:0] ax;
        logic [127:0] ay;
        logic [127:0] az;
        logic [127:0] s;
        ax = 128'(dx < 0 ? -dx : dx);
        ay = 128'(dy < 0 ? -dy : dy);
        az = 128'(dz < 0 ? -dz : dz);
        s = ax * ax + ay * ay + az * az;
        return root128({64'd0, root128(s << 16)});
    endfunction

    // n*m/den with the magnitude truncated and capped at 2^60.
    function automatic wide_t capped_ratio(input wide_t n, input logic [63:0] m,
                                           input logic [63:0] den);
        logic [127:0] p;
        logic [127:0] q;
        p = 128'(n < 0 ? -n : n) * 128'(m);
        q = p / 128'(den);
        if (q > (128'd1 << 60)) begin
            q = 128'd1 << 60;
        end
        return n < 0 ? -wide_t'(q) : wide_t'(q);
    endfunction

    function automatic logic signed [COEF_W-1:0] clip_coef(input wide_t x);
        if (x > wide_t'((64'sd1 <<< 39) - 1)) begin
            return {1'b0, {(COEF_W-1){1'b1}}};
        end else if (x < -wide_t'(64'sd1 <<< 39)) begin
            return {1'b1, {(COEF_W-1){1'b0}}};
        end
        return x[COEF_W-1:0];
    endfunction

    task automatic build_segment(input wide_t p [4][3]);
        wide_t d10 [3];
        wide_t d21 [3];
        wide_t d32 [3];
        wide_t co [4];
        wide_t m1;
        wide_t m2;
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] w;
        logic degen;
        out_item_t r;
        for (int c = 0; c < 3; c++) begin
            d10[c] = p[1][c] - p[0][c];
            d21[c] = p[2][c] - p[1][c];
            d32[c] = p[3][c] - p[2][c];
        end
        u = knot_len(d10[0], d10[1], d10[2]);
        v = knot_len(d21[0], d21[1], d21[2]);
        w = knot_len(d32[0], d32[1], d32[2]);
        degen = (u == 0 || v == 0 || w == 0);
        segments_built++;
        if (degen) begin
            degen_segments++;
        end
        for (int c = 0; c < 3; c++) begin
            co = '{default: '0};
            if (!degen) begin
                m1 = d21[c] + capped_ratio(wide_t'(v) * d10[c] - wide_t'(u) * d21[c], v,
                                           u * (u + v));
                m2 = d21[c] + capped_ratio(wide_t'(v) * d32[c] - wide_t'(w) * d21[c], v,
                                           w * (v + w));
                co[0] = p[1][c];
                co[1] = m1;
                co[2] = 3 * d21[c] - 2 * m1 - m2;
                co[3] = m1 + m2 - 2 * d21[c];
            end
            for (int j = 0; j < 4; j++) begin
                r.coefficient    = clip_coef(co[j]);
                r.axis           = 2'(c);
                r.power          = 2'(j);
                r.segment_number = SEGNUM_W'(seg_count);
                r.degenerate     = degen;
                r.run_end        = 1'b0;
                coef_q = {coef_q, r};
            end
        end
        seg_count = seg_count + 1'b1;
    endtask

    task automatic predict_point(input in_item_t it);
        wide_t q [4][3];
        wide_t s [4][3];
        int unsigned n;
        int start_len;
        out_item_t last;
        n = pts_seen;
        start_len = coef_q.size();
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
                q[k][c] = win[k][c];
            end
        end
        q[3][0] = wide_t'(it.coord_x);
        q[3][1] = wide_t'(it.coord_y);
        q[3][2] = wide_t'(it.coord_z);
        if (n >= 2) begin
            s = q;
            if (n == 2) begin
                for (int c = 0; c < 3; c++) begin
                    s[0][c] = 2 * q[1][c] - q[2][c];
                end
            end
            build_segment(s);
        end
        if (it.final_point && n >= 1) begin
            // Closing segment, with a mirrored point past the end of the list.
            for (int c = 0; c < 3; c++) begin
                s[0][c] = (n == 1) ? 2 * q[2][c] - q[3][c] : q[1][c];
                s[1][c] = q[2][c];
                s[2][c] = q[3][c];
                s[3][c] = 2 * q[3][c] - q[2][c];
            end
            build_segment(s);
        end
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
                win[k][c] = q[k+1][c];
            end
        end
        pts_seen = (n < 3) ? n + 1 : 3;
        if (it.final_point) begin
            pts_seen = 0;
            seg_count = '0;
            lists_done++;
        end
        if (coef_q.size() > start_len) begin
            last = coef_q[coef_q.size() - 1];
            last.run_end = 1'b1;
            coef_q[coef_q.size() - 1] = last;
        end
    endtask

    // Point input and result checking at the rising edge.
    always @(posedge aclk) begin
        out_item_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("status: fail");
            $finish;
        end else if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_point(s_data);
                points_taken <= points_taken + 1;
            end
            if (m_valid && m_ready) begin
                coefs_taken <= coefs_taken + 1;
                if (coef_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, m_data);
                    fail_count++;
                end else begin
                    want = coef_q.pop_front();
                    if (m_data !== want) begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, m_data);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Point driver with a random gap before every point.
    int gap_left;
    always @(negedge aclk) begin
        logic offer;
        logic taken;
        taken = s_valid && (points_taken == points_issued);
        offer = s_valid && !taken;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!offer) begin
            if (taken) begin
                gap_left = $urandom_range(0, 6);
            end
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (point_q.size() > 0) begin
                s_data <= point_q.pop_front();
                s_valid <= 1'b1;
                points_issued++;
                gap_left = $urandom_range(0, 6);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off to back up the input.
    int  hold_left;
    int  seen_coefs;
    logic long_hold_done;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (coefs_taken != seen_coefs) begin
                seen_coefs = coefs_taken;
                if (!long_hold_done && coefs_taken >= LONG_HOLD_AT) begin
                    long_hold_done = 1'b1;
                    hold_left = LONG_HOLD_CYCLES;
                end else begin
                    hold_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [31:0] pick_coord(input int mode);
        case (mode)
            0: return 32'($signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000);
            1: return $urandom();
            default: return ($urandom_range(0, 1) == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    task automatic add_point(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z, input logic fin);
        in_item_t it;
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        it.final_point = fin;
        point_q = {point_q, it};
    endtask

    initial begin
        in_item_t prev;
        int len;
        int mode;
        int total;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        win = '{default: '0};
        pts_seen = 0;
        seg_count = '0;
        points_taken = 0;
        coefs_taken = 0;
        points_issued = 0;
        fail_count = 0;
        lists_done = 0;
        segments_built = 0;
        degen_segments = 0;
        cycle_count = 0;
        gap_left = 0;
        hold_left = 0;
        seen_coefs = 0;
        long_hold_done = 1'b0;

        // A lone final point gives nothing; a two-point list gives one segment.
        add_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b1);
        add_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0);
        add_point(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 1'b1);
        // Coincident points make the knot spacing zero.
        add_point(32'sh0005_0000, 32'sh0005_0000, 32'sh0005_0000, 1'b0);
        add_point(32'sh0005_0000, 32'sh0005_0000, 32'sh0005_0000, 1'b0);
        add_point(32'sh0007_0000, -32'sh0001_0000, 32'sh0002_0000, 1'b1);
        // Full-scale jumps drive the coefficients into saturation.
        add_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        add_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        add_point(-32'sh1, 32'sh0, 32'sh1, 1'b0);
        add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
        // A longer list of small points reaches the steady window.
        for (int i = 0; i < 7; i++) begin
            add_point(pick_coord(0), pick_coord(0), pick_coord(0), i == 6);
        end

        total = 0;
        while (total < RANDOM_POINTS) begin
            len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
            prev = '0;
            for (int i = 0; i < len; i++) begin
                mode = $urandom_range(0, 19);
                if (i > 0 && mode < 3) begin
                    add_point(prev.coord_x, prev.coord_y, prev.coord_z, i == len - 1);
                end else begin
                    mode = (mode < 14) ? 0 : (mode < 19) ? 1 : 2;
                    add_point(pick_coord(mode), pick_coord(mode), pick_coord(mode),
                              i == len - 1);
                end
                prev = point_q[point_q.size() - 1];
                total++;
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        wait (point_q.size() == 0 && !s_valid && coef_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d points in %0d lists: %0d segments, %0d degenerate.",
                 points_taken, lists_done, segments_built, degen_segments);
        $display("Checked %0d coefficients, including saturation and one long output stall.",
                 coefs_taken);
        if (fail_count == 0 && coef_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== centripetal_spline_segment_builder_top.f =====
sv/cspline_pkg.sv
sv/cspline_ctrl.sv
sv/cspline_dp.sv
sv/centripetal_spline_segment_builder_top.sv
sv/cspline_chk.sv
tb/centripetal_spline_segment_builder_top_test.sv
